// ===== src/lle_pkg.sv =====
// ----------------------------------------------------------------------------
// lle_pkg
// Types and constants shared by the leader election block and its channels.
// ----------------------------------------------------------------------------
`default_nettype none

package lle_pkg;

   localparam int TIME_W      = 32;
   localparam int ID_W        = 48;
   localparam int PEERS_W     = 7;
   localparam int CHECKS_W    = 8;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 48;

   localparam logic [CHECKS_W-1:0] CHECKS_MAX = '1;

   localparam logic                MESH_ATTACHED_RST = 1'b1;
   localparam logic [ID_W-1:0]     OWN_ID_RST        = '0;
   localparam logic [TIME_W-1:0]   WAIT_TIMEOUT_RST  = 32'd5000;
   localparam logic [TIME_W-1:0]   HOLD_TIME_RST     = 32'd3000;
   localparam logic [CHECKS_W-1:0] CHECKS_NEEDED_RST = 8'd3;

   typedef enum logic [1:0] {
      PH_WAIT      = 2'd0,
      PH_STABILIZE = 2'd1,
      PH_ELECT     = 2'd2,
      PH_STABLE    = 2'd3
   } phase_type;

   typedef enum logic [1:0] {
      ROLE_STANDBY = 2'd0,
      ROLE_MASTER  = 2'd1,
      ROLE_SLAVE   = 2'd2
   } role_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_MESH_ATTACHED = 3'd0,
      CSR_OWN_ID        = 3'd1,
      CSR_WAIT_TIMEOUT  = 3'd2,
      CSR_HOLD_TIME     = 3'd3,
      CSR_CHECKS_NEEDED = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic                mesh_attached;
      logic [ID_W-1:0]     own_id;
      logic [TIME_W-1:0]   wait_timeout;
      logic [TIME_W-1:0]   hold_time;
      logic [CHECKS_W-1:0] checks_needed;
   } cfg_type;

endpackage

`default_nettype wire

// ===== src/lle_channels.sv =====
// ----------------------------------------------------------------------------
// lle channels
// Valid/ready channel interfaces for polls, results and register writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface lle_req_if;
   import lle_pkg::*;
   logic               valid;
   logic               ready;
   logic [TIME_W-1:0]  now_ms;
   logic [PEERS_W-1:0] online_peers;
   logic [ID_W-1:0]    lowest_peer_id;

   modport source (output valid, now_ms, online_peers, lowest_peer_id, input ready);
   modport sink   (input valid, now_ms, online_peers, lowest_peer_id, output ready);
endinterface

interface lle_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] role;
   logic [1:0] phase;
   logic       election_done;

   modport source (output valid, role, phase, election_done, input ready);
   modport sink   (input valid, role, phase, election_done, output ready);
endinterface

interface lle_csr_if;
   import lle_pkg::*;
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [CSR_DATA_W-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== src/lle_csr_regs.sv =====
// ----------------------------------------------------------------------------
// lle_csr_regs
// Configuration register file; always ready, unknown indexes are dropped.
// ----------------------------------------------------------------------------
`default_nettype none

module lle_csr_regs (
   input  wire logic        clock,
   input  wire logic        reset,
   lle_csr_if.sink          csr_ch,
   output lle_pkg::cfg_type cfg
);
   import lle_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ch.ready = 1'b1;
   assign cfg          = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_ch.valid) begin
         case (csr_index_type'(csr_ch.index))
            CSR_MESH_ATTACHED: cfg_in.mesh_attached = csr_ch.data[0];
            CSR_OWN_ID:        cfg_in.own_id        = csr_ch.data[ID_W-1:0];
            CSR_WAIT_TIMEOUT:  cfg_in.wait_timeout  = csr_ch.data[TIME_W-1:0];
            CSR_HOLD_TIME:     cfg_in.hold_time     = csr_ch.data[TIME_W-1:0];
            CSR_CHECKS_NEEDED: cfg_in.checks_needed = csr_ch.data[CHECKS_W-1:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mesh_attached <= MESH_ATTACHED_RST;
         cfg_ff.own_id        <= OWN_ID_RST;
         cfg_ff.wait_timeout  <= WAIT_TIMEOUT_RST;
         cfg_ff.hold_time     <= HOLD_TIME_RST;
         cfg_ff.checks_needed <= CHECKS_NEEDED_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

// ===== src/lowest_id_leader_election.sv =====
// ----------------------------------------------------------------------------
// lowest_id_leader_election
// Polled leader election: wait, let the peer count settle, then elect the
// lowest identifier; watch for lower peers or lost peers once stable.
// ----------------------------------------------------------------------------
//   channel  dir  carries
//   req_ch   in   now_ms, online_peers, lowest_peer_id (one poll)
//   rsp_ch   out  role, phase, election_done (one result per poll)
//   csr_ch   in   index, data (register write, always ready)
//
// One poll per cycle sustained while rsp_ch is ready; each poll passes
// through the poll register, then the phase/role update stage, whose state is
// the result. Synchronous reset puts the block in waiting/standby with default
// registers. A stalled result holds the update stage; the poll register still
// takes one more poll, after which req_ch.ready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module lowest_id_leader_election #(
   parameter int ID_BITS   = 48,
   parameter int MAX_PEERS = 64
) (
   input  wire logic clock,
   input  wire logic reset,
   lle_req_if.sink   req_ch,
   lle_rsp_if.source rsp_ch,
   lle_csr_if.sink   csr_ch
);
   import lle_pkg::*;

   localparam int CNT_W  = $clog2(MAX_PEERS + 1);
   localparam int WIDE_W = PEERS_W + 1;
   localparam int CMP_W  = (ID_BITS < ID_W) ? ID_BITS : ID_W;

   cfg_type cfg;

   lle_csr_regs u_csr (
      .clock  (clock),
      .reset  (reset),
      .csr_ch (csr_ch),
      .cfg    (cfg)
   );

   // poll register
   logic              in_valid_ff, in_valid_in;
   logic [TIME_W-1:0] now_ff;
   logic [CNT_W-1:0]  count_ff;
   logic [ID_W-1:0]   peer_ff;

   // election state, which is also the result register
   logic                out_valid_ff, out_valid_in;
   phase_type           phase_ff, phase_in;
   role_type            role_ff, role_in;
   logic                started_ff, started_in;
   logic [TIME_W-1:0]   wait_start_ff, wait_start_in;
   logic [TIME_W-1:0]   stable_since_ff, stable_since_in;
   logic [CNT_W-1:0]    last_count_ff, last_count_in;
   logic [CHECKS_W-1:0] checks_ff, checks_in;

   logic                advance;
   logic                accept;
   logic [WIDE_W-1:0]   peers_wide;
   logic [WIDE_W-1:0]   peers_clamped;
   logic [TIME_W-1:0]   wait_origin;
   logic [TIME_W-1:0]   wait_elapsed;
   logic [TIME_W-1:0]   hold_elapsed;
   logic [CHECKS_W-1:0] checks_next;
   logic                peer_lower;
   logic                no_peers;

   assign advance      = in_valid_ff && (!out_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !in_valid_ff || !out_valid_ff || rsp_ch.ready;
   assign accept       = req_ch.valid && req_ch.ready;

   assign peers_wide    = {1'b0, req_ch.online_peers};
   assign peers_clamped = (peers_wide > WIDE_W'(MAX_PEERS)) ? WIDE_W'(MAX_PEERS)
                                                            : peers_wide;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (accept) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         out_valid_in = 1'b0;
      end
   end

   // first poll after reset with the mesh attached stamps the wait start
   assign wait_origin  = started_ff ? wait_start_ff : now_ff;
   assign wait_elapsed = now_ff - wait_origin;
   assign hold_elapsed = now_ff - stable_since_ff;
   assign checks_next  = (checks_ff == CHECKS_MAX) ? checks_ff : checks_ff + 1'b1;
   assign peer_lower   = peer_ff[CMP_W-1:0] < cfg.own_id[CMP_W-1:0];
   assign no_peers     = (count_ff == '0);

   // next phase
   always_comb begin
      phase_in = phase_ff;
      if (!cfg.mesh_attached) begin
         phase_in = PH_STABLE;
      end else begin
         case (phase_ff)
            PH_WAIT: begin
               if (wait_elapsed >= cfg.wait_timeout) phase_in = PH_STABILIZE;
            end
            PH_STABILIZE: begin
               if (count_ff == last_count_ff && hold_elapsed >= cfg.hold_time &&
                   checks_next >= cfg.checks_needed) begin
                  phase_in = PH_ELECT;
               end
            end
            PH_ELECT: begin
               phase_in = PH_STABLE;
            end
            default: begin
               if (role_ff == ROLE_SLAVE && no_peers) phase_in = PH_ELECT;
            end
         endcase
      end
   end

   // role, stamps and check counter
   always_comb begin
      role_in         = role_ff;
      started_in      = started_ff;
      wait_start_in   = wait_start_ff;
      stable_since_in = stable_since_ff;
      last_count_in   = last_count_ff;
      checks_in       = checks_ff;
      if (!cfg.mesh_attached) begin
         role_in = ROLE_MASTER;
      end else begin
         started_in    = 1'b1;
         wait_start_in = wait_origin;
         case (phase_ff)
            PH_WAIT: begin
               if (wait_elapsed >= cfg.wait_timeout) begin
                  stable_since_in = now_ff;
                  last_count_in   = count_ff;
               end
            end
            PH_STABILIZE: begin
               if (count_ff != last_count_ff) begin
                  stable_since_in = now_ff;
                  last_count_in   = count_ff;
                  checks_in       = '0;
               end else if (hold_elapsed >= cfg.hold_time) begin
                  checks_in = checks_next;
               end
            end
            PH_ELECT: begin
               role_in = (no_peers || !peer_lower) ? ROLE_MASTER : ROLE_SLAVE;
            end
            default: begin
               // anything but slave behaves as master here
               if (role_ff != ROLE_SLAVE && !no_peers && peer_lower) begin
                  role_in = ROLE_SLAVE;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         now_ff   <= req_ch.now_ms;
         count_ff <= peers_clamped[CNT_W-1:0];
         peer_ff  <= req_ch.lowest_peer_id;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff     <= 1'b0;
         out_valid_ff    <= 1'b0;
         phase_ff        <= PH_WAIT;
         role_ff         <= ROLE_STANDBY;
         started_ff      <= 1'b0;
         wait_start_ff   <= '0;
         stable_since_ff <= '0;
         last_count_ff   <= '0;
         checks_ff       <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            phase_ff        <= phase_in;
            role_ff         <= role_in;
            started_ff      <= started_in;
            wait_start_ff   <= wait_start_in;
            stable_since_ff <= stable_since_in;
            last_count_ff   <= last_count_in;
            checks_ff       <= checks_in;
         end
      end
   end

   assign rsp_ch.valid         = out_valid_ff;
   assign rsp_ch.role          = role_ff;
   assign rsp_ch.phase         = phase_ff;
   assign rsp_ch.election_done = (phase_ff == PH_STABLE);

`ifndef ASSERT_OFF
   // once stable, an election has named a role
   a_stable_has_role: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && phase_ff == PH_STABLE) |-> (role_ff != ROLE_STANDBY))
      else $error("stable phase with standby role");

   // state only moves when a poll passes into the result stage
   a_state_holds: assert property (@(posedge clock) disable iff (reset)
      !advance |=> ($stable(phase_ff) && $stable(role_ff) && $stable(checks_ff)))
      else $error("election state changed without a poll");

   // a detached block reports master and stable
   a_detached_master: assert property (@(posedge clock) disable iff (reset)
      (advance && !cfg.mesh_attached) |=> (role_ff == ROLE_MASTER && phase_ff == PH_STABLE))
      else $error("detached block not master and stable");
`endif

endmodule

`default_nettype wire
